// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RLE palette decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCXRD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcxrd assertion failed");
`define PCXRD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pcxrd assertion failed");
`else
`define PCXRD_ASSERT(label, clk, rst, prop)
`define PCXRD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: hw/rtl/pcxrd_pkg.sv
// Package: constants, types and helpers of the RLE palette decoder.
package pcxrd_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int COUNT_BITS    = 24;

   localparam int BYTE_W     = 8;
   localparam int PIXEL_W    = 24;
   localparam int RUN_W      = 6;
   localparam int SIZE_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [BYTE_W-1:0] RUN_MARK      = 8'd192;
   localparam logic [BYTE_W:0]   PAL_DEPTH_LIM = (BYTE_W + 1)'(PALETTE_DEPTH);

   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_IMAGE   = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_OVERRUN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_ON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SIZE = 2'd1;

   typedef struct packed {
      logic                  palette_on;
      logic [COUNT_BITS-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [RUN_W-1:0]   cnt;
      logic               err;
   } cmd_type;

   function automatic logic [COUNT_BITS-1:0] count_limit(input logic [SIZE_W-1:0] size);
      logic [31:0] cap;
      logic [31:0] size32;
      cap    = (32'd1 << COUNT_BITS) - 32'd1;
      size32 = 32'(size);
      return (size32 < cap) ? COUNT_BITS'(size32) : COUNT_BITS'(cap);
   endfunction

endpackage

// File: hw/rtl/pcxrd_if.sv
// Request and response channel interfaces of the RLE palette decoder.
interface pcxrd_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  code_byte;
   logic [7:0]  entry_index;
   logic [23:0] entry_colour;

   modport source (output valid, output op, output code_byte, output entry_index,
                   output entry_colour, input ready);
   modport sink   (input valid, input op, input code_byte, input entry_index,
                   input entry_colour, output ready);
endinterface

interface pcxrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel;
   logic        last_of_run;
   logic        image_done;
   logic        status;

   modport source (output valid, output pixel, output last_of_run, output image_done,
                   output status, input ready);
   modport sink   (input valid, input pixel, input last_of_run, input image_done,
                   input status, output ready);
endinterface

// File: hw/rtl/pcxrd_ram.sv
// Generic simple dual-port RAM with registered read.
module pcxrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/pcxrd_queue.sv
// Command queue between the decoder front end and the emitter.
`include "assert_macros.svh"

module pcxrd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pcxrd_pkg::cmd_type       push_entry,
   input  logic                     pop,
   output pcxrd_pkg::cmd_type       head_entry,
   output logic [pcxrd_pkg::Q_CNT_W-1:0] count
);
   import pcxrd_pkg::*;

   cmd_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   `PCXRD_ASSERT(a_q_no_overflow, clock, reset, !(push && count_ff == Q_CNT_W'(Q_DEPTH)))
   `PCXRD_ASSERT(a_q_no_underflow, clock, reset, pop |-> count_ff != '0)

endmodule

// File: hw/rtl/pcxrd_front.sv
// Front end: accepts requests, tracks runs and count, looks up the palette.
`include "assert_macros.svh"

module pcxrd_front (
   input  logic                          clock,
   input  logic                          reset,
   pcxrd_req_if.sink                     req,
   input  pcxrd_pkg::cfg_type            cfg,
   input  logic [pcxrd_pkg::Q_CNT_W-1:0] q_count,
   output logic                          q_push,
   output pcxrd_pkg::cmd_type            q_entry
);
   import pcxrd_pkg::*;

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);

   logic                  accept;
   logic [Q_CNT_W:0]      occupancy;
   logic [RUN_W-1:0]      run_cnt;
   logic [COUNT_BITS:0]   count_sum;
   logic                  pal_we;
   logic                  pal_re;
   logic [PIXEL_W-1:0]    pal_rdata;

   logic                  run_pending_ff, run_pending_in;
   logic [RUN_W-1:0]      run_len_ff, run_len_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  err_ff, err_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_err_ff, s1_err_in;
   logic [BYTE_W-1:0]     s1_byte_ff;
   logic [RUN_W-1:0]      s1_cnt_ff;
   logic                  s1_inrange_ff, s1_inrange_in;

   assign occupancy = {1'b0, q_count} + {{Q_CNT_W{1'b0}}, s1_valid_ff};
   assign req.ready = occupancy < (Q_CNT_W + 1)'(Q_DEPTH);
   assign accept    = req.valid && req.ready;

   assign run_cnt       = run_pending_ff ? run_len_ff : RUN_W'(1);
   assign count_sum     = {1'b0, count_ff} + (COUNT_BITS + 1)'(run_cnt);
   assign s1_inrange_in = {1'b0, req.code_byte} < PAL_DEPTH_LIM;
   assign pal_re        = accept && (req.op == OP_IMAGE);
   assign pal_we        = accept && (req.op == OP_PALETTE) &&
                          ({1'b0, req.entry_index} < PAL_DEPTH_LIM);

   always_comb begin
      run_pending_in = run_pending_ff;
      run_len_in     = run_len_ff;
      count_in       = count_ff;
      err_in         = err_ff;
      s1_valid_in    = 1'b0;
      s1_err_in      = 1'b0;
      if (accept && req.op == OP_IMAGE) begin
         if (err_ff) begin
            s1_valid_in = 1'b1;
            s1_err_in   = 1'b1;
         end else if (count_ff >= cfg.limit) begin
            s1_valid_in = 1'b0;
         end else if (!run_pending_ff && req.code_byte >= RUN_MARK) begin
            run_pending_in = 1'b1;
            run_len_in     = req.code_byte[RUN_W-1:0];
         end else begin
            run_pending_in = 1'b0;
            run_len_in     = '0;
            if (count_sum > {1'b0, cfg.limit}) begin
               err_in      = 1'b1;
               s1_valid_in = 1'b1;
               s1_err_in   = 1'b1;
            end else if (run_cnt != '0) begin
               s1_valid_in = 1'b1;
               count_in    = count_sum[COUNT_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_pending_ff <= 1'b0;
         run_len_ff     <= '0;
         count_ff       <= '0;
         err_ff         <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         run_pending_ff <= run_pending_in;
         run_len_ff     <= run_len_in;
         count_ff       <= count_in;
         err_ff         <= err_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_re) begin
         s1_err_ff     <= s1_err_in;
         s1_byte_ff    <= req.code_byte;
         s1_cnt_ff     <= run_cnt;
         s1_inrange_ff <= s1_inrange_in;
      end
   end

   pcxrd_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (req.entry_index[PAL_AW-1:0]),
      .wdata (req.entry_colour),
      .re    (pal_re),
      .raddr (req.code_byte[PAL_AW-1:0]),
      .rdata (pal_rdata)
   );

   always_comb begin
      q_entry.err = s1_err_ff;
      if (s1_err_ff) begin
         q_entry.pixel = '0;
         q_entry.cnt   = RUN_W'(1);
      end else begin
         q_entry.cnt = s1_cnt_ff;
         if (cfg.palette_on) begin
            q_entry.pixel = s1_inrange_ff ? pal_rdata : '0;
         end else begin
            q_entry.pixel = PIXEL_W'(s1_byte_ff);
         end
      end
   end

   assign q_push = s1_valid_ff;

   `PCXRD_ASSERT(a_err_sticky, clock, reset, err_ff |=> err_ff)
   `PCXRD_ASSERT(a_count_in_limit, clock, reset, $past(accept) |-> count_ff <= cfg.limit || $past(count_ff) == count_ff)

endmodule

// File: hw/rtl/pcxrd_back.sv
// Back end: expands queued commands into one response per cycle while the receiver is ready.
`include "assert_macros.svh"

module pcxrd_back (
   input  logic               clock,
   input  logic               reset,
   input  pcxrd_pkg::cfg_type cfg,
   input  logic               q_valid,
   input  pcxrd_pkg::cmd_type q_entry,
   output logic               q_pop,
   pcxrd_rsp_if.source        rsp
);
   import pcxrd_pkg::*;

   logic                  advance;
   logic                  emit;
   logic                  cur_last;
   logic                  done_now;

   logic                  cur_valid_ff, cur_valid_in;
   cmd_type               cur_ff, cur_in;
   logic [COUNT_BITS-1:0] bk_cnt_ff, bk_cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]    out_pixel_ff;
   logic                  out_last_ff;
   logic                  out_done_ff;
   logic                  out_status_ff;

   assign advance  = !out_valid_ff || rsp.ready;
   assign emit     = advance && cur_valid_ff;
   assign cur_last = cur_ff.err || (cur_ff.cnt == RUN_W'(1));
   assign q_pop    = q_valid && (!cur_valid_ff || (emit && cur_last));
   assign done_now = !cur_ff.err &&
                     (({1'b0, bk_cnt_ff} + (COUNT_BITS + 1)'(1)) >= {1'b0, cfg.limit});

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      bk_cnt_in    = bk_cnt_ff;
      if (emit) begin
         if (cur_last) begin
            cur_valid_in = 1'b0;
         end else begin
            cur_in.cnt = cur_ff.cnt - RUN_W'(1);
         end
         if (!cur_ff.err) begin
            bk_cnt_in = bk_cnt_ff + COUNT_BITS'(1);
         end
      end
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_entry;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         bk_cnt_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         bk_cnt_ff    <= bk_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_pixel_ff  <= cur_ff.pixel;
         out_last_ff   <= cur_last;
         out_done_ff   <= done_now;
         out_status_ff <= cur_ff.err ? STATUS_OVERRUN : STATUS_OK;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel       = out_pixel_ff;
   assign rsp.last_of_run = out_last_ff;
   assign rsp.image_done  = out_done_ff;
   assign rsp.status      = out_status_ff;

   `PCXRD_ASSERT(a_err_rsp_shape, clock, reset, (out_valid_ff && out_status_ff == STATUS_OVERRUN) |-> (out_last_ff && !out_done_ff))

endmodule

// File: hw/rtl/pcx_rle_palette_decoder.sv
// Top level of the run-length palette decoder: config registers and wiring.
//
// Requests arrive on req_if (valid/ready). op selects a palette entry write
// or one coded image byte. Decoded pixels leave on rsp_if (valid/ready).
// Registers are written through csr_we/csr_index/csr_wdata, by the user only
// while idle (the block does not enforce this): index 0 palette_on, index 1 image_size.
// A literal byte's response passes the stage-1 register, the command queue,
// the current-command register and the output register; a run of n copies
// gives n responses. The front end accepts one request per cycle while the
// queue has room; palette writes and run headers make no response.
// Throughput is set by the emitter, one response per cycle while rsp_if is
// ready: a run holds it, and the 4-entry command queue then fills and drops ready.
// Palette lookups use the single palette RAM, read at acceptance.
// Reset clears the run state, the output count, the error flag and the
// registers; the palette contents are unknown until written.
// A stalled receiver holds the output register; the queue and the stage-1
// register together take up to four commands before req_if.ready falls.
module pcx_rle_palette_decoder (
   input  logic                             clock,
   input  logic                             reset,
   pcxrd_req_if.sink                        req_if,
   pcxrd_rsp_if.source                      rsp_if,
   input  logic                             csr_we,
   input  logic [pcxrd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcxrd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pcxrd_pkg::*;

   logic                  palette_on_ff, palette_on_in;
   logic [COUNT_BITS-1:0] limit_ff, limit_in;
   cfg_type               cfg;
   logic                  q_push;
   logic                  q_pop;
   cmd_type               q_push_entry;
   cmd_type               q_head;
   logic [Q_CNT_W-1:0]    q_count;

   always_comb begin
      palette_on_in = palette_on_ff;
      limit_in      = limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PALETTE_ON: palette_on_in = csr_wdata[0];
            CSR_IMAGE_SIZE: limit_in      = count_limit(csr_wdata[SIZE_W-1:0]);
            default:        palette_on_in = palette_on_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_on_ff <= 1'b0;
         limit_ff      <= '0;
      end else begin
         palette_on_ff <= palette_on_in;
         limit_ff      <= limit_in;
      end
   end

   assign cfg.palette_on = palette_on_ff;
   assign cfg.limit      = limit_ff;

   pcxrd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .cfg     (cfg),
      .q_count (q_count),
      .q_push  (q_push),
      .q_entry (q_push_entry)
   );

   pcxrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .count      (q_count)
   );

   pcxrd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_count != '0),
      .q_entry (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_if)
   );

endmodule

// File: tb/pcxrd_checker.sv
// Checker for the RLE palette decoder: predicts decoded pixels from requests and compares.
`timescale 1ns / 1ps
module pcxrd_checker (
   input  logic                              clock,
   input  logic                              reset,
   pcxrd_req_if                              req_mon,
   pcxrd_rsp_if                              rsp_mon,
   input  logic                              csr_we,
   input  logic [pcxrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcxrd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                failures,
   output int                                outstanding,
   output logic [pcxrd_pkg::COUNT_BITS-1:0]  pixels_emitted
);
   import pcxrd_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last_of_run;
      logic               image_done;
      logic               status;
   } pixel_beat_type;

   pixel_beat_type         expected_pixels[$];
   logic [PIXEL_W-1:0]     colour_table [PALETTE_DEPTH];
   logic                   cfg_palette_on;
   logic [SIZE_W-1:0]      cfg_image_size;
   logic                   run_armed;
   logic [RUN_W-1:0]       run_copies;
   logic [COUNT_BITS-1:0]  out_count;
   logic                   overrun_seen;
   int                     mismatch_count = 0;

   function automatic pixel_beat_type overrun_beat();
      pixel_beat_type b;
      b.pixel       = '0;
      b.last_of_run = 1'b1;
      b.image_done  = 1'b0;
      b.status      = STATUS_OVERRUN;
      return b;
   endfunction

   function automatic void decode_code_byte(input logic op, input logic [7:0] code_val,
                                            input logic [7:0] idx, input logic [23:0] colour);
      logic [31:0]        cap;
      logic [31:0]        limit;
      logic [31:0]        copies;
      logic [PIXEL_W-1:0] value;
      pixel_beat_type     b;
      cap   = (32'd1 << COUNT_BITS) - 32'd1;
      limit = (32'(cfg_image_size) < cap) ? 32'(cfg_image_size) : cap;
      if (op == OP_PALETTE) begin
         if (32'(idx) < PALETTE_DEPTH) colour_table[idx] = colour;
         return;
      end
      if (overrun_seen) begin
         expected_pixels.push_back(overrun_beat());
         return;
      end
      if (32'(out_count) >= limit) return;
      if (!run_armed && code_val >= RUN_MARK) begin
         run_armed  = 1'b1;
         run_copies = RUN_W'(code_val - RUN_MARK);
         return;
      end
      if (run_armed) begin
         copies     = 32'(run_copies);
         run_armed  = 1'b0;
         run_copies = '0;
      end else begin
         copies = 32'd1;
      end
      if (32'(out_count) + copies > limit) begin
         overrun_seen = 1'b1;
         expected_pixels.push_back(overrun_beat());
         return;
      end
      if (cfg_palette_on)
         value = (32'(code_val) < PALETTE_DEPTH) ? colour_table[code_val] : '0;
      else
         value = PIXEL_W'(code_val);
      for (int k = 0; k < int'(copies); k++) begin
         out_count     = out_count + 1'b1;
         b.pixel       = value;
         b.last_of_run = (k + 1 == int'(copies));
         b.image_done  = (32'(out_count) >= limit);
         b.status      = STATUS_OK;
         expected_pixels.push_back(b);
      end
   endfunction

   always @(posedge clock) begin
      pixel_beat_type want;
      if (reset) begin
         expected_pixels.delete();
         cfg_palette_on = 1'b0;
         cfg_image_size = '0;
         run_armed      = 1'b0;
         run_copies     = '0;
         out_count      = '0;
         overrun_seen   = 1'b0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected response: pixel %h status %b", rsp_mon.pixel, rsp_mon.status);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_mon.pixel !== want.pixel) begin
                  $error("pixel: expected %h, actual %h", want.pixel, rsp_mon.pixel);
                  mismatch_count++;
               end
               if (rsp_mon.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b",
                         want.last_of_run, rsp_mon.last_of_run);
                  mismatch_count++;
               end
               if (rsp_mon.image_done !== want.image_done) begin
                  $error("image_done: expected %b, actual %b",
                         want.image_done, rsp_mon.image_done);
                  mismatch_count++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %b, actual %b", want.status, rsp_mon.status);
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PALETTE_ON: cfg_palette_on = csr_wdata[0];
               CSR_IMAGE_SIZE: cfg_image_size = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            decode_code_byte(req_mon.op, req_mon.code_byte, req_mon.entry_index,
                             req_mon.entry_colour);
      end
      failures       <= mismatch_count;
      outstanding    <= expected_pixels.size();
      pixels_emitted <= out_count;
   end
endmodule

// File: tb/testbench.sv
// Testbench top for the RLE palette decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import pcxrd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    failures;
   int                    outstanding;
   logic [COUNT_BITS-1:0] pixels_emitted;
   bit                    quiet;
   bit                    pal_mode;
   int                    gap_pct;
   int                    room;

   pcxrd_req_if req_if ();
   pcxrd_rsp_if rsp_if ();

   pcx_rle_palette_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pcxrd_checker decode_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .outstanding    (outstanding),
      .pixels_emitted (pixels_emitted)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // receiver stalls in bursts; none once quiet is set
   initial begin
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_PALETTE_ON) pal_mode = data[0];
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(input logic op, input logic [7:0] code_val, input logic [7:0] idx,
                       input logic [23:0] colour);
      if (gap_pct > $urandom_range(0, 99)) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.op           <= op;
      req_if.code_byte    <= code_val;
      req_if.entry_index  <= idx;
      req_if.entry_colour <= colour;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic send_byte(input logic [7:0] code_val);
      send(OP_IMAGE, code_val, 8'($urandom), 24'($urandom));
   endtask

   task automatic send_palette(input logic [7:0] idx, input logic [23:0] colour);
      send(OP_PALETTE, 8'($urandom), idx, colour);
   endtask

   // in palette mode values are drawn from entries 0..31 and 224..255, loaded up front
   function automatic logic [7:0] value_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (pal_mode) b[6:5] = {b[7], b[7]};
      return b;
   endfunction

   function automatic logic [7:0] literal_byte();
      return pal_mode ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, RUN_MARK - 1));
   endfunction

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // well-formed runs and literals, mixed with palette writes, stray bytes and split headers
   task automatic random_phase(input int n_items);
      bit         open;
      int         pick;
      int         len;
      logic [7:0] b;
      open = 1'b0;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_palette(8'($urandom), 24'($urandom));
         end else if (open) begin
            send_byte(value_byte());
            open = 1'b0;
         end else if (pick < 15) begin
            b = value_byte();
            send_byte(b);
            open = (b >= RUN_MARK);
         end else if (pick < 50) begin
            send_byte(literal_byte());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(0, 6);
            else if (pick < 95) len = $urandom_range(7, 20);
            else len = $urandom_range(21, 63);
            send_byte(RUN_MARK + 8'(len));
            open = 1'b1;
         end
      end
      if (open) send_byte(value_byte());
   endtask

   // keeps the output count within the image size until room drops to stop_room
   task automatic budget_stream(input int stop_room);
      int len;
      while (room > stop_room) begin
         case ($urandom_range(0, 3))
            0: send_palette(8'($urandom), 24'($urandom));
            1: begin
               send_byte(literal_byte());
               room--;
            end
            default: begin
               len = $urandom_range(0, (room - stop_room < 63) ? room - stop_room : 63);
               send_byte(RUN_MARK + 8'(len));
               send_byte(value_byte());
               room -= len;
            end
         endcase
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_PALETTE_ON;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.op            = OP_IMAGE;
      req_if.code_byte     = '0;
      req_if.entry_index   = '0;
      req_if.entry_colour  = '0;
      quiet                = 1'b0;
      pal_mode             = 1'b0;
      gap_pct              = 20;
      room                 = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_SPARE_2, CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_3, CSR_DATA_W'($urandom));
      write_reg(CSR_PALETTE_ON, '0);
      write_reg(CSR_IMAGE_SIZE, '0);

      // entries 0..31 and 224..255 loaded up front; palette-mode values come from them
      for (int i = 0; i < 64; i++)
         send_palette((i < 32) ? 8'(i) : 8'(i + 192), (i == 0) ? 24'h000000 :
                      (i == 63) ? 24'hFFFFFF : 24'($urandom));
      // empty image: bytes dropped
      send_byte(8'h05);
      send_byte(RUN_MARK + 8'd4);
      send_byte(8'h10);
      wait_idle();

      write_reg(CSR_IMAGE_SIZE, 24'hFFFFFF);
      send_byte(8'h00);
      send_byte(RUN_MARK - 8'd1);
      send_byte(RUN_MARK);
      send_byte(8'h55);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(RUN_MARK + 8'd1);
      send_byte(RUN_MARK);
      send_byte(RUN_MARK + 8'd3);
      send_byte(8'h00);
      wait_idle();

      write_reg(CSR_PALETTE_ON, 24'd1);
      send_byte(8'h00);
      send_byte(8'h1F);
      send_palette(8'h10, 24'hFFFFFF);
      send_byte(8'h10);
      send_palette(8'h10, 24'h000000);
      send_byte(8'h10);
      send_byte(RUN_MARK + 8'd2);
      send_byte(8'hFF);
      send_byte(RUN_MARK);
      send_byte(8'h20);
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         gap_pct = (p == 1) ? 0 : 10 + 15 * p;
         write_reg(CSR_PALETTE_ON, CSR_DATA_W'(p % 2));
         random_phase(40);
         wait_idle();
      end

      // fill the image exactly, then bytes past the end
      gap_pct = 20;
      write_reg(CSR_PALETTE_ON, CSR_DATA_W'($urandom_range(0, 1)));
      room = $urandom_range(10, 40);
      write_reg(CSR_IMAGE_SIZE, CSR_DATA_W'(pixels_emitted) + CSR_DATA_W'(room));
      budget_stream(0);
      repeat (5) send_byte(8'($urandom));
      wait_idle();

      // size shrunk below the count already emitted
      write_reg(CSR_IMAGE_SIZE, '0);
      repeat (3) send_byte(8'($urandom));
      wait_idle();

      // no idling from here; ends in a latched overrun
      quiet   = 1'b1;
      gap_pct = 0;
      write_reg(CSR_PALETTE_ON, CSR_DATA_W'($urandom_range(0, 1)));
      room = $urandom_range(20, 40);
      write_reg(CSR_IMAGE_SIZE, CSR_DATA_W'(pixels_emitted) + CSR_DATA_W'(room));
      budget_stream(8);
      send_byte(8'hFF);
      send_byte(8'($urandom));
      repeat (3) send_byte(8'($urandom));
      send_palette(8'($urandom), 24'($urandom));
      repeat (3) send_byte(8'($urandom));
      wait_idle();

      if (failures == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
